/* hw/rtl/rqpp_pkg.sv */
// ----------------------------------------------------------------------------
// rqpp_pkg - ready queue with priority pick, shared definitions
// Field widths, command and status codes, and the types passed between the
// top level and the row of queue cells.
// ----------------------------------------------------------------------------
package rqpp_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int CMD_W  = 3;
	localparam int PID_W  = 16;
	localparam int PRIO_W = 8;
	localparam int ST_W   = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PICK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
	localparam logic [ST_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [ST_W-1:0] STAT_NOTFOUND = 2'd3;

	// search word that travels down the cell row
	typedef struct packed {
		logic              mode_pick;
		logic              hit;
		logic [PID_W-1:0]  key_pid;
		logic [PID_W-1:0]  best_pid;
		logic [PRIO_W-1:0] best_prio;
	} rqpp_word_t;

	// storage update controls broadcast to every cell
	typedef struct packed {
		logic push;
		logic shift;
	} rqpp_ctrl_t;

endpackage

/* hw/rtl/rqpp_cell.sv */
// ----------------------------------------------------------------------------
// rqpp_cell - one slot of the ready queue
// Holds one entry, takes part in the search sweep as one stage and shifts
// towards the head when an entry at or before it is taken out.
// ----------------------------------------------------------------------------
module rqpp_cell #(
	parameter int CAPACITY = 16,
	parameter int INDEX    = 0,
	parameter int CNT_W    = $clog2(CAPACITY + 1),
	parameter int IDX_W    = $clog2(CAPACITY)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rqpp_pkg::rqpp_ctrl_t       ctrl,
	input  logic [CNT_W-1:0]           occ,
	input  logic [IDX_W-1:0]           sel,
	input  logic [rqpp_pkg::PID_W-1:0] wr_pid,
	input  logic [rqpp_pkg::PRIO_W-1:0] wr_prio,
	input  logic [rqpp_pkg::PID_W-1:0] nxt_pid,
	input  logic [rqpp_pkg::PRIO_W-1:0] nxt_prio,
	output logic [rqpp_pkg::PID_W-1:0] ent_pid,
	output logic [rqpp_pkg::PRIO_W-1:0] ent_prio,
	input  logic                       act_in,
	input  rqpp_pkg::rqpp_word_t       word_in,
	input  logic [IDX_W-1:0]           idx_in,
	output logic                       act_out,
	output rqpp_pkg::rqpp_word_t       word_out,
	output logic [IDX_W-1:0]           idx_out
);
	import rqpp_pkg::*;

	logic [PID_W-1:0]  pid_q;
	logic [PRIO_W-1:0] prio_q;
	logic              act_q;
	rqpp_word_t        word_q;
	logic [IDX_W-1:0]  idx_q;

	logic       occupied;
	logic       better;
	logic       take;
	rqpp_word_t word_nx;

	// entry storage: push at the tail slot, shift towards the head
	always_ff @(posedge clk) begin
		if (ctrl.push && occ == CNT_W'(INDEX)) begin
			pid_q  <= wr_pid;
			prio_q <= wr_prio;
		end else if (ctrl.shift && sel <= IDX_W'(INDEX)) begin
			pid_q  <= nxt_pid;
			prio_q <= nxt_prio;
		end
	end

	assign ent_pid  = pid_q;
	assign ent_prio = prio_q;

	// search stage: first pid match, or best priority with lower pid on ties
	always_comb begin
		occupied = CNT_W'(INDEX) < occ;
		better   = (prio_q > word_in.best_prio) ||
			(prio_q == word_in.best_prio && pid_q < word_in.best_pid);
		if (word_in.mode_pick) begin
			take = occupied && (!word_in.hit || better);
		end else begin
			take = occupied && !word_in.hit && (pid_q == word_in.key_pid);
		end
		word_nx = word_in;
		if (take) begin
			word_nx.hit       = 1'b1;
			word_nx.best_pid  = pid_q;
			word_nx.best_prio = prio_q;
		end
	end

	// sweep valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= act_in;
		end
	end

	// sweep payload
	always_ff @(posedge clk) begin
		word_q <= word_nx;
		idx_q  <= take ? IDX_W'(INDEX) : idx_in;
	end

	assign act_out  = act_q;
	assign word_out = word_q;
	assign idx_out  = idx_q;

endmodule

/* hw/rtl/ready_queue_with_priority_pick_top.sv */
// ----------------------------------------------------------------------------
// ready_queue_with_priority_pick_top - ordered ready queue with priority pick
// A row of CAPACITY cells holds the entries in arrival order, head in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; it
//   carries cmd, pid and priority_req. Every request gives one result on
//   found, out_pid, out_priority, count and status, shown for exactly one
//   cycle with done high. The receiver cannot stall; results are never held.
//   Push, pop head, peek head, unused codes and any request on an empty
//   queue finish without a search: done is high in the cycle after the
//   request, busy stays low and a new request may be given in every cycle.
//   Remove by pid and pop highest priority on a non-empty queue send a search
//   word down the cell row, one cell per cycle, then close the gap as the
//   result is loaded: done follows once the word leaves the last cell, and
//   busy is high while the word is in the row, which is as long as the row.
//   Reset empties the queue (occupancy zero) and clears any sweep in flight;
//   the entry storage itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module ready_queue_with_priority_pick_top #(
	parameter int CAPACITY = rqpp_pkg::CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rqpp_pkg::CMD_W-1:0]  cmd,
	input  logic [rqpp_pkg::PID_W-1:0]  pid,
	input  logic [rqpp_pkg::PRIO_W-1:0] priority_req,
	output logic                        done,
	output logic                        found,
	output logic [rqpp_pkg::PID_W-1:0]  out_pid,
	output logic [rqpp_pkg::PRIO_W-1:0] out_priority,
	output logic [CNT_W-1:0]            count,
	output logic [rqpp_pkg::ST_W-1:0]   status
);
	import rqpp_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_SWEEP = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] occ_q;

	logic             done_q;
	logic             found_q;
	logic [PID_W-1:0] pid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [CNT_W-1:0] count_q;
	logic [ST_W-1:0]  status_q;

	logic             accept;
	logic             empty;
	logic             full;
	logic             finish;
	rqpp_ctrl_t       ctrl;
	logic [IDX_W-1:0] sel;
	logic             inject;
	rqpp_word_t       inj_word;

	logic             res_load;
	logic             res_found;
	logic [PID_W-1:0] res_pid;
	logic [PRIO_W-1:0] res_prio;
	logic [CNT_W-1:0] res_count;
	logic [ST_W-1:0]  res_status;

	logic [PID_W-1:0]  ent_pid  [CAPACITY+1];
	logic [PRIO_W-1:0] ent_prio [CAPACITY+1];
	logic              act_c    [CAPACITY+1];
	rqpp_word_t        word_c   [CAPACITY+1];
	logic [IDX_W-1:0]  idx_c    [CAPACITY+1];

	assign accept = start && !busy;
	assign busy   = (state_q == ST_SWEEP);
	assign empty  = (occ_q == '0);
	assign full   = (occ_q >= CNT_W'(CAPACITY));
	assign finish = (state_q == ST_SWEEP) && act_c[CAPACITY];

	// search word entering the first cell
	always_comb begin
		inject             = accept && !empty && (cmd == CMD_REMOVE || cmd == CMD_PICK);
		inj_word.mode_pick = (cmd == CMD_PICK);
		inj_word.hit       = 1'b0;
		inj_word.key_pid   = pid;
		inj_word.best_pid  = '0;
		inj_word.best_prio = '0;
	end

	assign act_c[0]  = inject;
	assign word_c[0] = inj_word;
	assign idx_c[0]  = '0;

	// no entry past the last cell
	assign ent_pid[CAPACITY]  = '0;
	assign ent_prio[CAPACITY] = '0;

	// command decode: storage controls and the result of this cycle
	always_comb begin
		ctrl.push  = 1'b0;
		ctrl.shift = 1'b0;
		sel        = '0;
		res_load   = 1'b0;
		res_found  = 1'b0;
		res_pid    = '0;
		res_prio   = '0;
		res_count  = occ_q;
		res_status = STAT_OK;
		if (finish) begin
			res_load   = 1'b1;
			ctrl.shift = word_c[CAPACITY].hit;
			sel        = idx_c[CAPACITY];
			if (word_c[CAPACITY].hit) begin
				res_found = 1'b1;
				res_pid   = word_c[CAPACITY].best_pid;
				res_prio  = word_c[CAPACITY].best_prio;
				res_count = occ_q - CNT_W'(1);
			end else begin
				res_status = STAT_NOTFOUND;
			end
		end else if (accept && !inject) begin
			res_load = 1'b1;
			unique case (cmd) inside
				CMD_PUSH: begin
					if (full) begin
						res_status = STAT_FULL;
					end else begin
						ctrl.push = 1'b1;
						res_found = 1'b1;
						res_pid   = pid;
						res_prio  = priority_req;
						res_count = occ_q + CNT_W'(1);
					end
				end
				CMD_POP, CMD_PEEK, CMD_REMOVE, CMD_PICK: begin
					if (empty) begin
						res_status = STAT_EMPTY;
					end else begin
						res_found = 1'b1;
						res_pid   = ent_pid[0];
						res_prio  = ent_prio[0];
						if (cmd == CMD_POP) begin
							ctrl.shift = 1'b1;
							res_count  = occ_q - CNT_W'(1);
						end
					end
				end
				default: begin
					res_found = 1'b0;
				end
			endcase
		end
	end

	// control state and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= res_load;
			if (res_load) begin
				occ_q <= res_count;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (inject) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q  <= res_found;
			pid_q    <= res_pid;
			prio_q   <= res_prio;
			count_q  <= res_count;
			status_q <= res_status;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign out_pid      = pid_q;
	assign out_priority = prio_q;
	assign count        = count_q;
	assign status       = status_q;

	// row of queue cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rqpp_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i),
			.CNT_W    (CNT_W),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.occ      (occ_q),
			.sel      (sel),
			.wr_pid   (pid),
			.wr_prio  (priority_req),
			.nxt_pid  (ent_pid[i+1]),
			.nxt_prio (ent_prio[i+1]),
			.ent_pid  (ent_pid[i]),
			.ent_prio (ent_prio[i]),
			.act_in   (act_c[i]),
			.word_in  (word_c[i]),
			.idx_in   (idx_c[i]),
			.act_out  (act_c[i+1]),
			.word_out (word_c[i+1]),
			.idx_out  (idx_c[i+1])
		);
	end

endmodule
